@@ src/lom_pkg.sv @@
// Shared types and constants for the limit order matcher.
// No dependencies.
package lom_pkg;
  localparam int unsigned BOOK_DEPTH_DEF  = 32;
  localparam int unsigned NUM_STOCKS_DEF  = 16;
  localparam int unsigned NUM_TRADERS_DEF = 256;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned TRADER_W = 8;
  localparam int unsigned STOCK_W = 4;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned DL_W    = 26;
  localparam logic [DL_W-1:0] NEVER_DL = DL_W'(1) << 25;
  localparam logic [47:0] MAX_MONEY  = '1;
  localparam logic [31:0] MAX_FILLS  = '1;
  localparam logic [39:0] MAX_SHARES = '1;

  typedef struct packed {
    logic                is_sell;
    logic [STOCK_W-1:0]  stock;
    logic [TRADER_W-1:0] trader;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
    logic [DL_W-1:0]     deadline;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_SCAN, ST_FILL, ST_FREE, ST_EMIT, ST_SUM
  } state_t;
endpackage

@@ src/lom_book_mem.sv @@
// Order table storage: one synchronous RAM with a registered read port.
// Depends on lom_pkg.
module lom_book_mem
  import lom_pkg::*;
#(
  parameter int unsigned DEPTH = BOOK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/limit_order_matcher.sv @@
// Top level of the limit order matcher: sequencer, valid flags, totals.
// Depends on lom_pkg and lom_book_mem.
//
//  channel | signals                      | direction
//  input   | in_valid/in_ready + fields   | into block
//  output  | out_valid/out_ready + fields | out of block
//
// Sequence: accept, then an expiry sweep over the table only on a time change;
// per fill one table scan, ST_FILL to form the word and ST_EMIT with a
// write-back as it leaves; a closing scan (cut short if nothing is left or the
// order is invalid), ST_FREE to rest in the lowest free entry, then the summary word.
// The single RAM read port sets the scan length.
// Reset clears flags, totals and time; table contents need none.
// A stalled output holds the sequencer in place.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH  = BOOK_DEPTH_DEF,
  parameter int unsigned NUM_STOCKS  = NUM_STOCKS_DEF,
  parameter int unsigned NUM_TRADERS = NUM_TRADERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        arrival_time,
  input  logic [7:0]         trader_id,
  input  logic               is_sell,
  input  logic [3:0]         stock_id,
  input  logic [19:0]        limit_price,
  input  logic [15:0]        quantity,
  input  logic               has_expiry,
  input  logic [23:0]        expiry_span,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_fill,
  output logic [7:0]         buyer_id,
  output logic [7:0]         seller_id,
  output logic [15:0]        fill_quantity,
  output logic [19:0]        fill_price,
  output logic               rested,
  output logic               book_full,
  output logic [47:0]        total_money,
  output logic [31:0]        trade_count,
  output logic [39:0]        share_count,
  output logic               last
);
  localparam int unsigned AW = $clog2(BOOK_DEPTH);
  localparam int unsigned CW = AW + 1;

  state_t state, state_next;
  logic [BOOK_DEPTH-1:0] valid;
  logic [TIME_W-1:0] cur_time;
  logic [47:0] money;
  logic [31:0] fills;
  logic [39:0] shares;

  // latched order
  logic [TIME_W-1:0] o_time;
  logic [TRADER_W-1:0] o_trader;
  logic o_sell;
  logic [STOCK_W-1:0] o_stock;
  logic [PRICE_W-1:0] o_limit;
  logic [QTY_W-1:0] rem;
  logic [DL_W-1:0] o_dl;
  logic ok;

  logic [CW-1:0] cnt;     // issued read address count
  logic rd_pend;          // rdata belongs to index rd_idx
  logic [AW-1:0] rd_idx;
  logic have_best;
  logic [AW-1:0] best_idx;
  entry_t best;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, rdata;

  lom_book_mem #(.DEPTH(BOOK_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );

  // wrap to entry 0 at the end of a pass
  assign mem_raddr = (cnt == CW'(BOOK_DEPTH)) ? '0 : cnt[AW-1:0];
  assign in_ready = (state == ST_IDLE);

  logic [QTY_W-1:0] fq;
  assign fq = (best.qty < rem) ? best.qty : rem;

  // candidate test and ranking on the word just read
  logic cand, ahead;
  always_comb begin
    cand = valid[rd_idx] && (rdata.is_sell != o_sell) && (rdata.stock == o_stock)
           && (o_sell ? (rdata.price >= o_limit) : (rdata.price <= o_limit));
    if (!have_best) ahead = 1'b1;
    else if (rdata.price != best.price)
      ahead = o_sell ? (rdata.price > best.price) : (rdata.price < best.price);
    else if (rdata.deadline != best.deadline) ahead = rdata.deadline < best.deadline;
    else ahead = rdata.trader < best.trader;
  end

  // first free entry by priority
  logic free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--)
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
  end

  logic [47:0] prod;
  logic [48:0] msum;
  logic [40:0] ssum;
  assign prod = 48'(fq) * 48'(best.price);
  assign msum = {1'b0, money} + {1'b0, prod};
  assign ssum = {1'b0, shares} + 41'(fq);

  logic scan_done;
  assign scan_done = rd_pend && (rd_idx == AW'(BOOK_DEPTH - 1));

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = best;
    mem_wdata.qty = best.qty - fq;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next =
                  (arrival_time != cur_time) ? ST_SWEEP : ST_SCAN;
      ST_SWEEP: if (scan_done) state_next = ST_SCAN;
      ST_SCAN: begin
        if (!ok || rem == '0) state_next = ST_FREE;
        else if (scan_done) state_next = (have_best || cand) ? ST_FILL : ST_FREE;
      end
      ST_FILL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_next = ST_SCAN;
        mem_we = out_ready;
      end
      ST_FREE: begin
        state_next = ST_SUM;
        mem_we = ok && rem != '0 && free_found;
        mem_waddr = free_idx;
        mem_wdata = '{is_sell: o_sell, stock: o_stock, trader: o_trader,
                      price: o_limit, qty: rem, deadline: o_dl};
      end
      ST_SUM:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; cur_time <= '0; money <= '0; fills <= '0; shares <= '0;
      cnt <= '0; rd_pend <= 1'b0; have_best <= 1'b0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          have_best <= 1'b0;
          if (in_valid) begin
            o_time <= arrival_time; o_trader <= trader_id; o_sell <= is_sell;
            o_stock <= stock_id; o_limit <= limit_price; rem <= quantity;
            o_dl <= has_expiry ? DL_W'(arrival_time) + DL_W'(expiry_span) : NEVER_DL;
            ok <= (32'(stock_id) < NUM_STOCKS) && (32'(trader_id) < NUM_TRADERS)
                  && quantity != '0;
            cnt <= CW'(1);
            rd_pend <= 1'b1;
            rd_idx <= '0;
            if (arrival_time != cur_time) cur_time <= arrival_time;
          end else begin
            cnt <= '0; rd_pend <= 1'b0;
          end
        end
        ST_SWEEP: begin
          if (valid[rd_idx] && rdata.deadline < DL_W'(o_time)) valid[rd_idx] <= 1'b0;
          if (scan_done) begin
            cnt <= CW'(1); rd_idx <= '0;
          end else begin
            rd_idx <= cnt[AW-1:0];
            cnt <= cnt + CW'(1);
          end
        end
        ST_SCAN: begin
          if (cand && ahead) begin
            have_best <= 1'b1; best <= rdata; best_idx <= rd_idx;
          end
          if (scan_done) begin
            cnt <= '0; rd_idx <= '0;
          end else begin
            rd_idx <= cnt[AW-1:0];
            cnt <= cnt + CW'(1);
          end
        end
        ST_FILL: begin
          money <= msum[48] ? MAX_MONEY : msum[47:0];
          if (fills != MAX_FILLS) fills <= fills + 32'd1;
          shares <= ssum[40] ? MAX_SHARES : ssum[39:0];
          is_fill <= 1'b1;
          buyer_id <= o_sell ? best.trader : o_trader;
          seller_id <= o_sell ? o_trader : best.trader;
          fill_quantity <= fq;
          fill_price <= best.price;
          rested <= 1'b0; book_full <= 1'b0; last <= 1'b0;
          out_valid <= 1'b1;
        end
        ST_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          rem <= rem - fq;
          if (best.qty == fq) valid[best_idx] <= 1'b0;
          have_best <= 1'b0; cnt <= CW'(1); rd_idx <= '0;
        end
        ST_FREE: begin
          is_fill <= 1'b0; buyer_id <= '0; seller_id <= '0;
          fill_quantity <= '0; fill_price <= '0; last <= 1'b1;
          rested <= ok && rem != '0 && free_found;
          book_full <= ok && rem != '0 && !free_found;
          if (ok && rem != '0 && free_found) valid[free_idx] <= 1'b1;
          out_valid <= 1'b1;
          cnt <= '0;
        end
        ST_SUM: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign total_money = money;
  assign trade_count = fills;
  assign share_count = shares;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_last_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !is_fill) else $error("summary flagged as fill");
  a_rest_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rested && book_full)) else $error("rested and full together");
  a_fill_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_fill |-> fill_quantity != '0) else $error("empty fill");
endmodule
